// File: rtl/nbpc_pkg.sv
// shared types, codes and default sizes of the naive bayes pixel classifier
package nbpc_pkg;

   localparam int DEF_IMAGE_SIDE = 28;
   localparam int DEF_NUM_SHADES = 2;
   localparam int DEF_NUM_LABELS = 10;
   localparam int DEF_LOG_WIDTH  = 16;

   localparam int QUEUE_DEPTH = 4;

   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_FEATURE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PRIOR   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PIXEL   = 2'd2;

   localparam int PIXEL_W  = 10;
   localparam int SHADE_W  = 2;
   localparam int LABEL_W  = 4;
   localparam int VALUE_W  = 16;
   localparam int SCORE_W  = 32;

   typedef struct packed {
      logic [MODE_W-1:0] kind;
      logic              last;
      logic              pix_ok;
   } nbpc_ctrl_type;

endpackage

// File: rtl/naive_bayes_pixel_classifier_core.sv
// top level of the naive bayes pixel classifier
// Accepts one request word per cycle while the queue is not full (req_stall low): classify
// pixels and in-range feature and prior loads flow through a four-entry command queue into
// the back end, whose per-label feature memories are read one row per pixel into registers
// and summed into saturating 32-bit label accumulators. At the last pixel of an image the
// scores are handed to a search unit that scans one label per cycle, holding at the last
// label while the response register is stalled; a second image end reaching the back end
// while that search still runs waits for it. Feature and prior tables are not cleared by
// reset and must be loaded before use.
module naive_bayes_pixel_classifier_core #(
   parameter int IMAGE_SIDE = nbpc_pkg::DEF_IMAGE_SIDE,
   parameter int NUM_SHADES = nbpc_pkg::DEF_NUM_SHADES,
   parameter int NUM_LABELS = nbpc_pkg::DEF_NUM_LABELS,
   parameter int LOG_WIDTH  = nbpc_pkg::DEF_LOG_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [nbpc_pkg::MODE_W-1:0]         req_mode,
   input  logic [nbpc_pkg::PIXEL_W-1:0]        req_pixel_index,
   input  logic [nbpc_pkg::SHADE_W-1:0]        req_shade,
   input  logic [nbpc_pkg::LABEL_W-1:0]        req_label,
   input  logic signed [nbpc_pkg::VALUE_W-1:0] req_log_value,
   input  logic                                req_last_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nbpc_pkg::LABEL_W-1:0]        rsp_class_label,
   output logic signed [nbpc_pkg::SCORE_W-1:0] rsp_best_score
);
   import nbpc_pkg::*;

   localparam int NUM_ROWS = IMAGE_SIDE * IMAGE_SIDE * NUM_SHADES;
   localparam int ROW_W    = $clog2(NUM_ROWS);
   localparam int LBL_W    = $clog2(NUM_LABELS);
   localparam int CTRL_W   = $bits(nbpc_ctrl_type);
   localparam int QW       = CTRL_W + ROW_W + LBL_W + LOG_WIDTH;

   logic                 q_full;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_not_empty;
   logic [QW-1:0]        push_data;
   logic [QW-1:0]        pop_data;

   nbpc_ctrl_type        f_ctrl, b_ctrl;
   logic [ROW_W-1:0]     f_row, b_row;
   logic [LBL_W-1:0]     f_label, b_label;
   logic [LOG_WIDTH-1:0] f_value, b_value;

   nbpc_front #(
      .IMAGE_SIDE (IMAGE_SIDE),
      .NUM_SHADES (NUM_SHADES),
      .NUM_LABELS (NUM_LABELS),
      .LOG_WIDTH  (LOG_WIDTH),
      .ROW_W      (ROW_W),
      .LBL_W      (LBL_W)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_pixel_index (req_pixel_index),
      .req_shade       (req_shade),
      .req_label       (req_label),
      .req_log_value   (req_log_value),
      .req_last_pixel  (req_last_pixel),
      .q_full          (q_full),
      .q_push          (q_push),
      .cmd_ctrl        (f_ctrl),
      .cmd_row         (f_row),
      .cmd_label       (f_label),
      .cmd_value       (f_value)
   );

   assign push_data = {f_ctrl, f_row, f_label, f_value};

   nbpc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   assign {b_ctrl, b_row, b_label, b_value} = pop_data;

   nbpc_back #(
      .NUM_ROWS   (NUM_ROWS),
      .NUM_LABELS (NUM_LABELS),
      .LOG_WIDTH  (LOG_WIDTH),
      .ROW_W      (ROW_W),
      .LBL_W      (LBL_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_not_empty     (q_not_empty),
      .q_pop           (q_pop),
      .cmd_ctrl        (b_ctrl),
      .cmd_row         (b_row),
      .cmd_label       (b_label),
      .cmd_value       (b_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_class_label (rsp_class_label),
      .rsp_best_score  (rsp_best_score)
   );

endmodule

// File: rtl/nbpc_front.sv
// front end: decodes request words into queue commands
module nbpc_front #(
   parameter int IMAGE_SIDE = nbpc_pkg::DEF_IMAGE_SIDE,
   parameter int NUM_SHADES = nbpc_pkg::DEF_NUM_SHADES,
   parameter int NUM_LABELS = nbpc_pkg::DEF_NUM_LABELS,
   parameter int LOG_WIDTH  = nbpc_pkg::DEF_LOG_WIDTH,
   parameter int ROW_W      = 11,
   parameter int LBL_W      = 4
) (
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [nbpc_pkg::MODE_W-1:0]         req_mode,
   input  logic [nbpc_pkg::PIXEL_W-1:0]        req_pixel_index,
   input  logic [nbpc_pkg::SHADE_W-1:0]        req_shade,
   input  logic [nbpc_pkg::LABEL_W-1:0]        req_label,
   input  logic signed [nbpc_pkg::VALUE_W-1:0] req_log_value,
   input  logic                                req_last_pixel,
   input  logic                                q_full,
   output logic                                q_push,
   output nbpc_pkg::nbpc_ctrl_type             cmd_ctrl,
   output logic [ROW_W-1:0]                    cmd_row,
   output logic [LBL_W-1:0]                    cmd_label,
   output logic [LOG_WIDTH-1:0]                cmd_value
);
   import nbpc_pkg::*;

   localparam int NUM_PIXELS = IMAGE_SIDE * IMAGE_SIDE;
   localparam int LOG_MAX    = (1 << (LOG_WIDTH - 1)) - 1;
   localparam int LOG_MIN    = -LOG_MAX - 1;

   logic [SHADE_W-1:0] shade_c;
   logic               pix_ok;
   logic               lbl_ok;
   logic               useful;
   int                 val_i;

   assign req_stall = q_full;

   assign shade_c = (int'(req_shade) >= NUM_SHADES) ? SHADE_W'(NUM_SHADES - 1) : req_shade;
   assign pix_ok  = int'(req_pixel_index) < NUM_PIXELS;
   assign lbl_ok  = int'(req_label) < NUM_LABELS;
   assign val_i   = int'(req_log_value);

   always_comb begin
      unique case (req_mode)
         MODE_FEATURE: useful = pix_ok && lbl_ok;
         MODE_PRIOR:   useful = lbl_ok;
         MODE_PIXEL:   useful = 1'b1;
         default:      useful = 1'b0;
      endcase
   end

   assign q_push          = req_valid && !q_full && useful;
   assign cmd_ctrl.kind   = req_mode;
   assign cmd_ctrl.last   = req_last_pixel;
   assign cmd_ctrl.pix_ok = pix_ok;
   assign cmd_row   = ROW_W'(int'(req_pixel_index) * NUM_SHADES + int'(shade_c));
   assign cmd_label = LBL_W'(req_label);

   always_comb begin
      if (val_i > LOG_MAX) begin
         cmd_value = LOG_WIDTH'(LOG_MAX);
      end else if (val_i < LOG_MIN) begin
         cmd_value = LOG_WIDTH'(LOG_MIN);
      end else begin
         cmd_value = LOG_WIDTH'(val_i);
      end
   end

endmodule

// File: rtl/nbpc_queue.sv
// short command queue between front and back
module nbpc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = nbpc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/nbpc_back.sv
// back end: table storage, label accumulators, arg-max search and response register
module nbpc_back #(
   parameter int NUM_ROWS   = 1568,
   parameter int NUM_LABELS = nbpc_pkg::DEF_NUM_LABELS,
   parameter int LOG_WIDTH  = nbpc_pkg::DEF_LOG_WIDTH,
   parameter int ROW_W      = 11,
   parameter int LBL_W      = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_not_empty,
   output logic                                q_pop,
   input  nbpc_pkg::nbpc_ctrl_type             cmd_ctrl,
   input  logic [ROW_W-1:0]                    cmd_row,
   input  logic [LBL_W-1:0]                    cmd_label,
   input  logic [LOG_WIDTH-1:0]                cmd_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nbpc_pkg::LABEL_W-1:0]        rsp_class_label,
   output logic signed [nbpc_pkg::SCORE_W-1:0] rsp_best_score
);
   import nbpc_pkg::*;

   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

   logic                        is_pixel;
   logic                        issue;
   logic                        b_adv;
   logic                        b_step;
   logic                        b_vld_ff, b_vld_in;
   logic                        b_last_ff;
   logic                        b_pix_ok_ff;
   logic                        in_prog_ff, in_prog_in;

   logic signed [LOG_WIDTH-1:0] feat_rd_ff [NUM_LABELS];
   logic signed [LOG_WIDTH-1:0] prior_ff   [NUM_LABELS];
   logic signed [SCORE_W-1:0]   acc_ff     [NUM_LABELS];
   logic signed [SCORE_W-1:0]   sum        [NUM_LABELS];
   logic signed [SCORE_W-1:0]   snap_ff    [NUM_LABELS];

   logic                        srch_busy_ff, srch_busy_in;
   logic [LBL_W-1:0]            srch_idx_ff, srch_idx_in;
   logic [LBL_W-1:0]            best_idx_ff, best_idx_in;
   logic signed [SCORE_W-1:0]   best_score_ff, best_score_in;
   logic signed [SCORE_W-1:0]   cand;
   logic                        better;
   logic                        srch_end;
   logic                        srch_go;
   logic                        out_free;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [LBL_W-1:0]            rsp_idx_ff;
   logic signed [SCORE_W-1:0]   rsp_score_ff;

   assign is_pixel = cmd_ctrl.kind == MODE_PIXEL;
   assign b_adv    = !(b_last_ff && srch_busy_ff);
   assign b_step   = b_vld_ff && b_adv;
   assign q_pop    = q_not_empty && (!b_vld_ff || b_adv);
   assign issue    = q_pop && is_pixel;

   for (genvar k = 0; k < NUM_LABELS; k++) begin : g_lane
      logic [LOG_WIDTH-1:0] feat_mem [NUM_ROWS];

      always_ff @(posedge clock) begin
         if (q_pop && cmd_ctrl.kind == MODE_FEATURE && cmd_label == LBL_W'(k)) begin
            feat_mem[cmd_row] <= cmd_value;
         end
         if (issue) begin
            feat_rd_ff[k] <= feat_mem[cmd_row];
         end
         if (q_pop && cmd_ctrl.kind == MODE_PRIOR && cmd_label == LBL_W'(k)) begin
            prior_ff[k] <= cmd_value;
         end
      end
   end

   always_comb begin
      logic signed [SCORE_W-1:0] base;
      logic signed [SCORE_W-1:0] addend;
      logic signed [SCORE_W:0]   wide;
      for (int k = 0; k < NUM_LABELS; k++) begin
         base   = in_prog_ff ? acc_ff[k] : SCORE_W'(prior_ff[k]);
         addend = b_pix_ok_ff ? SCORE_W'(feat_rd_ff[k]) : '0;
         wide   = (SCORE_W+1)'(base) + (SCORE_W+1)'(addend);
         if (wide[SCORE_W] != wide[SCORE_W-1]) begin
            sum[k] = wide[SCORE_W] ? SCORE_MIN : SCORE_MAX;
         end else begin
            sum[k] = wide[SCORE_W-1:0];
         end
      end
   end

   always_comb begin
      b_vld_in   = b_vld_ff;
      in_prog_in = in_prog_ff;
      if (!b_vld_ff || b_adv) begin
         b_vld_in = issue;
      end
      if (b_step) begin
         in_prog_in = !b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff   <= 1'b0;
         in_prog_ff <= 1'b0;
      end else begin
         b_vld_ff   <= b_vld_in;
         in_prog_ff <= in_prog_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         b_last_ff   <= cmd_ctrl.last;
         b_pix_ok_ff <= cmd_ctrl.pix_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_LABELS; k++) begin
            acc_ff[k] <= '0;
         end
      end else if (b_step) begin
         for (int k = 0; k < NUM_LABELS; k++) begin
            acc_ff[k] <= sum[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_step && b_last_ff) begin
         for (int k = 0; k < NUM_LABELS; k++) begin
            snap_ff[k] <= sum[k];
         end
      end
   end

   // one label per cycle over the finished image's scores, holding at the last label while the response is stalled
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cand     = snap_ff[srch_idx_ff];
   assign better   = cand > best_score_ff;
   assign srch_end = srch_idx_ff == LBL_W'(NUM_LABELS - 1);
   assign srch_go  = srch_busy_ff && (!srch_end || out_free);

   always_comb begin
      srch_busy_in  = srch_busy_ff;
      srch_idx_in   = srch_idx_ff;
      best_idx_in   = best_idx_ff;
      best_score_in = best_score_ff;
      if (b_step && b_last_ff) begin
         srch_busy_in  = 1'b1;
         srch_idx_in   = LBL_W'(1);
         best_idx_in   = '0;
         best_score_in = sum[0];
      end else if (srch_go) begin
         srch_idx_in = srch_idx_ff + 1'b1;
         if (better) begin
            best_idx_in   = srch_idx_ff;
            best_score_in = cand;
         end
         if (srch_end) begin
            srch_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srch_busy_ff <= 1'b0;
      end else begin
         srch_busy_ff <= srch_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      srch_idx_ff   <= srch_idx_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (srch_go && srch_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (srch_go && srch_end) begin
         rsp_idx_ff   <= better ? srch_idx_ff : best_idx_ff;
         rsp_score_ff <= better ? cand : best_score_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_label = LABEL_W'(rsp_idx_ff);
   assign rsp_best_score  = rsp_score_ff;

endmodule

// File: rtl/nbpc_checker.sv
// port-level checker for the naive bayes pixel classifier, bound to the top level
module nbpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [nbpc_pkg::MODE_W-1:0]         req_mode,
   input logic                                req_last_pixel,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [nbpc_pkg::LABEL_W-1:0]        rsp_class_label,
   input logic signed [nbpc_pkg::SCORE_W-1:0] rsp_best_score
);
   import nbpc_pkg::*;

   localparam int MAX_PENDING = QUEUE_DEPTH + 3;

   logic       img_end;
   logic       rsp_take;
   logic [3:0] pending_ff, pending_in;

   assign img_end  = req_valid && !req_stall && req_mode == MODE_PIXEL && req_last_pixel;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (img_end && !rsp_take) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_take && !img_end) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_class_label)
         && $stable(rsp_best_score))
      else $error("stalled response word changed");

   a_rsp_has_image: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response word without a finished image");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(MAX_PENDING))
      else $error("more finished images in flight than the pipeline holds");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

endmodule

bind naive_bayes_pixel_classifier_core nbpc_checker u_nbpc_checker (.*);
